// ===== rtl/core/sgt_pkg.sv =====
// Shared types and constants of the staggered grid trilinear sampler.
package sgt_pkg;

    localparam int GRID_X_DEF = 16;
    localparam int GRID_Y_DEF = 16;
    localparam int GRID_Z_DEF = 16;

    localparam int VALUE_W = 32;
    localparam int CELL_W  = 4;
    localparam int INV_W   = 24;
    localparam int AXES_W  = 3;
    localparam int WEIGHT_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [INV_W-1:0]  INV_SPACING_RST = 24'd65536;
    localparam logic [AXES_W-1:0] SHIFT_AXES_RST  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AXES  = 1'b1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic signed [VALUE_W-1:0] pos_x;
        logic signed [VALUE_W-1:0] pos_y;
        logic signed [VALUE_W-1:0] pos_z;
        logic [CELL_W-1:0]         cell_x;
        logic [CELL_W-1:0]         cell_y;
        logic [CELL_W-1:0]         cell_z;
        logic signed [VALUE_W-1:0] entry_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] velocity;
        logic                      out_of_range;
    } t_out_item;

    // Clamped scaled coordinate of one axis, Q24.16 in cells
    typedef struct packed {
        logic        flag;
        logic [39:0] s;
    } t_axis;

endpackage

// ===== rtl/core/sgt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sgt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sgt_lerp.sv =====
// Two-stage linear blend a + round((b - a) * w / 2^16).
module sgt_lerp (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [sgt_pkg::VALUE_W-1:0] i_a,
    input  logic signed [sgt_pkg::VALUE_W-1:0] i_b,
    input  logic [sgt_pkg::WEIGHT_W-1:0]       i_w,
    output logic signed [sgt_pkg::VALUE_W-1:0] o_res
);
    import sgt_pkg::*;

    localparam int DW = VALUE_W + 1;
    localparam int PW = DW + WEIGHT_W + 1;

    logic signed [DW-1:0]      n_diff;
    logic signed [PW-1:0]      n_prod;
    logic signed [PW-1:0]      r_prod;
    logic signed [VALUE_W-1:0] r_a;
    logic signed [PW-1:0]      n_rnd;
    logic signed [PW-17:0]     n_sum;
    logic signed [VALUE_W-1:0] r_res;

    always_comb begin
        n_diff = {i_b[VALUE_W-1], i_b} - {i_a[VALUE_W-1], i_a};
        n_prod = PW'(n_diff * $signed({1'b0, i_w}));
    end

    // Result lies between a and b, so the low word holds it exactly
    always_comb begin
        n_rnd = r_prod + PW'(32768);
        n_sum = n_rnd[PW-1:16] + (PW-16)'(r_a);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_a    <= i_a;
            r_res  <= n_sum[VALUE_W-1:0];
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/core/staggered_grid_trilinear_sample.sv =====
// Each accepted sample item gives one result; write items give no result.
// Throughput: one item per cycle while the output is not stalled; eight parity banks deliver all corners in one read.
// The whole pipeline holds while the output register is full and stalled.
// Synchronous active-low reset clears valid bits and loads inv_spacing 1.0, shift_axes 6.
// Grid contents are not cleared by reset.
module staggered_grid_trilinear_sample #(
    parameter int GRID_X = sgt_pkg::GRID_X_DEF,
    parameter int GRID_Y = sgt_pkg::GRID_Y_DEF,
    parameter int GRID_Z = sgt_pkg::GRID_Z_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  sgt_pkg::t_in_item                 i_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output sgt_pkg::t_out_item                o_out,
    input  logic                              i_cfg_we,
    input  logic [sgt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sgt_pkg::INV_W-1:0]         i_cfg_data
);
    import sgt_pkg::*;

    localparam int XW = $clog2(GRID_X);
    localparam int YW = $clog2(GRID_Y);
    localparam int ZW = $clog2(GRID_Z);
    localparam int HX = (GRID_X + 1) / 2;
    localparam int HY = (GRID_Y + 1) / 2;
    localparam int HZ = (GRID_Z + 1) / 2;
    localparam int BANK_DEPTH = HX * HY * HZ;
    localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int NB = 8;
    localparam int MW = VALUE_W + INV_W + 1;
    localparam logic signed [40:0] HI_X = 41'((GRID_X - 1) * 65536 - 1);
    localparam logic signed [40:0] HI_Y = 41'((GRID_Y - 1) * 65536 - 1);
    localparam logic signed [40:0] HI_Z = 41'((GRID_Z - 1) * 65536 - 1);

    function automatic t_axis clamp_axis(input logic signed [MW-1:0] prod,
                                         input logic half,
                                         input logic signed [40:0] hi);
        logic signed [40:0] s;
        t_axis r;
        s = prod[MW-1:16] - (half ? 41'sd32768 : 41'sd0);
        r.flag = 1'b0;
        r.s = s[39:0];
        if (s < 0) begin
            r.s = '0;
            r.flag = 1'b1;
        end else if (s > hi) begin
            r.s = hi[39:0];
            r.flag = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] bank_addr(input logic [AW-1:0] xh,
                                                input logic [AW-1:0] yh,
                                                input logic [AW-1:0] zh);
        return (xh * AW'(HY) + yh) * AW'(HZ) + zh;
    endfunction

    logic en;
    logic [10:1] r_vld;

    logic [INV_W-1:0]  r_inv_spacing;
    logic [AXES_W-1:0] r_shift_axes;

    // stage 1: products
    logic                      r1_op;
    logic signed [MW-1:0]      r1_px, r1_py, r1_pz;
    logic [CELL_W-1:0]         r1_cx, r1_cy, r1_cz;
    logic signed [VALUE_W-1:0] r1_value;
    logic [AXES_W-1:0]         r1_shift;

    // stage 2: indices and weights
    t_axis                     n2_ax, n2_ay, n2_az;
    logic                      r2_op;
    logic [XW-1:0]             r2_ix;
    logic [YW-1:0]             r2_iy;
    logic [ZW-1:0]             r2_iz;
    logic [WEIGHT_W-1:0]       r2_wx, r2_wy, r2_wz;
    logic                      r2_flag;
    logic [CELL_W-1:0]         r2_cx, r2_cy, r2_cz;
    logic signed [VALUE_W-1:0] r2_value;

    // stage 3: bank addresses
    logic [AW-1:0]             n3_addr [NB];
    logic [NB-1:0]             n3_we;
    logic                      n3_in_grid;
    logic [AW-1:0]             r3_addr [NB];
    logic [NB-1:0]             r3_we;
    logic                      r3_op;
    logic [2:0]                r3_par;
    logic [WEIGHT_W-1:0]       r3_wx, r3_wy, r3_wz;
    logic                      r3_flag;
    logic signed [VALUE_W-1:0] r3_value;

    // stage 4 onward
    logic [VALUE_W-1:0]        w_rd [NB];
    logic signed [VALUE_W-1:0] w_corner [NB];
    logic [2:0]                r4_par;
    logic [WEIGHT_W-1:0]       r4_wx, r4_wy, r4_wz;
    logic [WEIGHT_W-1:0]       r5_wx, r5_wy, r6_wx, r6_wy;
    logic [WEIGHT_W-1:0]       r7_wx, r8_wx;
    logic [10:4]               r_flag;
    logic signed [VALUE_W-1:0] w_c00, w_c01, w_c10, w_c11, w_c0, w_c1, w_v;

    assign en      = !r_vld[10] || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_spacing <= INV_SPACING_RST;
            r_shift_axes  <= SHIFT_AXES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INV_SPACING: r_inv_spacing <= i_cfg_data;
                CFG_SHIFT_AXES:  r_shift_axes  <= i_cfg_data[AXES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld[1]     <= i_valid;
            r_vld[3:2]   <= r_vld[2:1];
            r_vld[4]     <= r_vld[3] && (r3_op == OP_SAMPLE);
            r_vld[10:5]  <= r_vld[9:4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op    <= i_in.operation;
            r1_px    <= MW'($signed(i_in.pos_x) * $signed({1'b0, r_inv_spacing}));
            r1_py    <= MW'($signed(i_in.pos_y) * $signed({1'b0, r_inv_spacing}));
            r1_pz    <= MW'($signed(i_in.pos_z) * $signed({1'b0, r_inv_spacing}));
            r1_cx    <= i_in.cell_x;
            r1_cy    <= i_in.cell_y;
            r1_cz    <= i_in.cell_z;
            r1_value <= i_in.entry_value;
            r1_shift <= r_shift_axes;
        end
    end

    always_comb begin
        n2_ax = clamp_axis(r1_px, r1_shift[0], HI_X);
        n2_ay = clamp_axis(r1_py, r1_shift[1], HI_Y);
        n2_az = clamp_axis(r1_pz, r1_shift[2], HI_Z);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_op    <= r1_op;
            r2_ix    <= n2_ax.s[16 +: XW];
            r2_iy    <= n2_ay.s[16 +: YW];
            r2_iz    <= n2_az.s[16 +: ZW];
            r2_wx    <= n2_ax.s[WEIGHT_W-1:0];
            r2_wy    <= n2_ay.s[WEIGHT_W-1:0];
            r2_wz    <= n2_az.s[WEIGHT_W-1:0];
            r2_flag  <= n2_ax.flag || n2_ay.flag || n2_az.flag;
            r2_cx    <= r1_cx;
            r2_cy    <= r1_cy;
            r2_cz    <= r1_cz;
            r2_value <= r1_value;
        end
    end

    // Bank b holds entries whose coordinate parities are {x, y, z} = b
    always_comb begin
        n3_in_grid = (32'(r2_cx) < GRID_X) && (32'(r2_cy) < GRID_Y)
                     && (32'(r2_cz) < GRID_Z);
        for (int b = 0; b < NB; b++) begin
            logic [XW-1:0] xb;
            logic [YW-1:0] yb;
            logic [ZW-1:0] zb;
            xb = r2_ix + XW'(r2_ix[0] != b[2]);
            yb = r2_iy + YW'(r2_iy[0] != b[1]);
            zb = r2_iz + ZW'(r2_iz[0] != b[0]);
            if (r2_op == OP_SAMPLE) begin
                n3_addr[b] = bank_addr(AW'(xb >> 1), AW'(yb >> 1), AW'(zb >> 1));
            end else begin
                n3_addr[b] = bank_addr(AW'(r2_cx >> 1), AW'(r2_cy >> 1),
                                       AW'(r2_cz >> 1));
            end
            n3_we[b] = r_vld[2] && (r2_op == OP_WRITE) && n3_in_grid
                       && ({r2_cx[0], r2_cy[0], r2_cz[0]} == 3'(b));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_we <= '0;
        end else if (en) begin
            r3_we <= n3_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_addr  <= n3_addr;
            r3_op    <= r2_op;
            r3_par   <= {r2_ix[0], r2_iy[0], r2_iz[0]};
            r3_wx    <= r2_wx;
            r3_wy    <= r2_wy;
            r3_wz    <= r2_wz;
            r3_flag  <= r2_flag;
            r3_value <= r2_value;
        end
    end

    for (genvar b = 0; b < NB; b++) begin : g_bank
        sgt_ram #(
            .WIDTH (VALUE_W),
            .DEPTH (BANK_DEPTH),
            .AW    (AW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (en && r3_we[b]),
            .i_waddr (r3_addr[b]),
            .i_wdata (r3_value),
            .i_re    (en),
            .i_raddr (r3_addr[b]),
            .o_rdata (w_rd[b])
        );
    end

    // Corner {dx, dy, dz} sits in the bank of its parities
    always_comb begin
        for (int c = 0; c < NB; c++) begin
            w_corner[c] = $signed(w_rd[3'(c) ^ r4_par]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_par <= r3_par;
            r4_wx  <= r3_wx;
            r4_wy  <= r3_wy;
            r4_wz  <= r3_wz;
            r5_wx  <= r4_wx;
            r5_wy  <= r4_wy;
            r6_wx  <= r5_wx;
            r6_wy  <= r5_wy;
            r7_wx  <= r6_wx;
            r8_wx  <= r7_wx;
            r_flag <= {r_flag[9:4], r3_flag};
        end
    end

    sgt_lerp u_lerp_z00 (.i_clk(i_clk), .i_en(en), .i_a(w_corner[0]), .i_b(w_corner[1]),
                         .i_w(r4_wz), .o_res(w_c00));
    sgt_lerp u_lerp_z01 (.i_clk(i_clk), .i_en(en), .i_a(w_corner[2]), .i_b(w_corner[3]),
                         .i_w(r4_wz), .o_res(w_c01));
    sgt_lerp u_lerp_z10 (.i_clk(i_clk), .i_en(en), .i_a(w_corner[4]), .i_b(w_corner[5]),
                         .i_w(r4_wz), .o_res(w_c10));
    sgt_lerp u_lerp_z11 (.i_clk(i_clk), .i_en(en), .i_a(w_corner[6]), .i_b(w_corner[7]),
                         .i_w(r4_wz), .o_res(w_c11));
    sgt_lerp u_lerp_y0  (.i_clk(i_clk), .i_en(en), .i_a(w_c00), .i_b(w_c01),
                         .i_w(r6_wy), .o_res(w_c0));
    sgt_lerp u_lerp_y1  (.i_clk(i_clk), .i_en(en), .i_a(w_c10), .i_b(w_c11),
                         .i_w(r6_wy), .o_res(w_c1));
    sgt_lerp u_lerp_x   (.i_clk(i_clk), .i_en(en), .i_a(w_c0), .i_b(w_c1),
                         .i_w(r8_wx), .o_res(w_v));

    assign o_valid            = r_vld[10];
    assign o_out.velocity     = w_v;
    assign o_out.out_of_range = r_flag[10];

endmodule
